[src/lpht_pkg.sv]
// lpht_pkg: shared types and constants of the linear-probing hash table
// no dependencies; used by every module under src
package lpht_pkg;

    localparam int KEY_W       = 16;
    localparam int VALUE_W     = 16;
    localparam int SLOT_W      = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } lpht_op_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } lpht_status_t;

    // one request as it travels from the front to the probe engine
    typedef struct packed {
        lpht_op_t             op;
        logic [KEY_W-1:0]     key;
        logic [VALUE_W-1:0]   value;
    } lpht_req_t;

    // one slot of the table memory
    typedef struct packed {
        logic                 occ;
        logic [KEY_W-1:0]     key;
        logic [VALUE_W-1:0]   value;
    } lpht_entry_t;

endpackage

[src/lpht_front.sv]
// lpht_front: accepts requests and computes the home slot (key modulo slots)
// by reciprocal multiplication, registering the quotient and then the remainder; depends on lpht_pkg
module lpht_front #(
    parameter int TABLE_SLOTS = 16,
    parameter int IDX_W       = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          hold,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [lpht_pkg::KEY_W-1:0]    s_key,
    input  logic [lpht_pkg::VALUE_W-1:0]  s_value,
    output logic                          push_valid,
    input  logic                          push_ready,
    output lpht_pkg::lpht_req_t           push_req,
    output logic [IDX_W-1:0]              push_home
);

    localparam int RECIP_SH = lpht_pkg::KEY_W + IDX_W;
    localparam int RECIP_W  = lpht_pkg::KEY_W + 2;
    localparam int PROD_W   = lpht_pkg::KEY_W + RECIP_W;
    localparam longint RECIP_L = ((longint'(1) << RECIP_SH) + longint'(TABLE_SLOTS) - 1)
                                 / longint'(TABLE_SLOTS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam logic [lpht_pkg::KEY_W-1:0] SLOTS_K = lpht_pkg::KEY_W'(TABLE_SLOTS);

    typedef enum logic [1:0] {
        F_IDLE,
        F_REM,
        F_PUSH
    } front_state_t;

    front_state_t                state_reg, state_next;
    lpht_pkg::lpht_req_t         req_reg, req_next;
    logic [lpht_pkg::KEY_W-1:0]  quo_reg, quo_next;
    logic [IDX_W-1:0]            rem_reg, rem_next;
    logic [PROD_W-1:0]           quo_full;
    logic [lpht_pkg::KEY_W-1:0]  rem_full;

    // quotient by reciprocal multiplication, exact for every key value
    assign quo_full = PROD_W'(s_key) * PROD_W'(RECIP);

    // remainder from the registered quotient
    assign rem_full = req_reg.key - lpht_pkg::KEY_W'(quo_reg * SLOTS_K);

    assign s_ready    = (state_reg == F_IDLE) && !hold;
    assign push_valid = (state_reg == F_PUSH);
    assign push_req   = req_reg;
    assign push_home  = rem_reg;

    // next-state logic
    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_valid && s_ready) begin
                    req_next.op    = lpht_pkg::lpht_op_t'(s_opcode);
                    req_next.key   = s_key;
                    req_next.value = s_value;
                    quo_next       = lpht_pkg::KEY_W'(quo_full >> RECIP_SH);
                    state_next     = F_REM;
                end
            end
            F_REM: begin
                rem_next   = IDX_W'(rem_full);
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    // state and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        req_reg <= req_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule

[src/lpht_fifo.sv]
// lpht_fifo: short request queue between front and probe engine
// depends on lpht_pkg for its depth
module lpht_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = lpht_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] buf_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign wr_ready = (cnt_reg != FULL_CNT);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = buf_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            buf_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/lpht_back.sv]
// lpht_back: probe engine with the slot memory and the result register
// clears the memory after reset; depends on lpht_pkg
module lpht_back #(
    parameter int TABLE_SLOTS = 16,
    parameter int IDX_W       = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    output logic                          clearing,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  lpht_pkg::lpht_req_t           q_req,
    input  logic [IDX_W-1:0]              q_home,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [lpht_pkg::VALUE_W-1:0]  m_found_value,
    output logic [lpht_pkg::SLOT_W-1:0]   m_slot
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CHECK,
        B_FINISH
    } back_state_t;

    back_state_t                   state_reg, state_next;
    lpht_pkg::lpht_req_t           req_reg, req_next;
    logic [IDX_W-1:0]              pos_reg, pos_next;
    logic [IDX_W-1:0]              cnt_reg, cnt_next;
    logic [IDX_W-1:0]              clr_reg, clr_next;
    lpht_pkg::lpht_status_t        res_status_reg, res_status_next;
    logic [lpht_pkg::VALUE_W-1:0]  res_fval_reg, res_fval_next;
    logic [IDX_W-1:0]              res_slot_reg, res_slot_next;
    logic                          m_valid_reg, m_valid_next;
    lpht_pkg::lpht_status_t        m_status_reg, m_status_next;
    logic [lpht_pkg::VALUE_W-1:0]  m_fval_reg, m_fval_next;
    logic [lpht_pkg::SLOT_W-1:0]   m_slot_reg, m_slot_next;

    lpht_pkg::lpht_entry_t         mem [TABLE_SLOTS];
    lpht_pkg::lpht_entry_t         rdata_reg;
    lpht_pkg::lpht_entry_t         wr_data;
    logic [IDX_W-1:0]              rd_addr, wr_addr;
    logic                          wr_en;

    logic [IDX_W-1:0]              pos_inc;
    logic                          key_match;
    logic                          is_insert;
    logic                          out_free;

    assign pos_inc   = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
    assign key_match = (rdata_reg.key == req_reg.key);
    assign is_insert = (req_reg.op == lpht_pkg::OP_INSERT);
    assign out_free  = !m_valid_reg || m_ready;

    assign clearing      = (state_reg == B_CLEAR);
    assign q_ready       = (state_reg == B_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_value = m_fval_reg;
    assign m_slot        = m_slot_reg;

    // read address runs one slot ahead while probing continues
    assign rd_addr = (state_reg == B_CHECK) ? pos_inc : pos_reg;

    // memory write: clearing sweep or an insert into an empty slot
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = '0;
        if (state_reg == B_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
        end else if (state_reg == B_CHECK && is_insert && !rdata_reg.occ) begin
            wr_en         = 1'b1;
            wr_data.occ   = 1'b1;
            wr_data.key   = req_reg.key;
            wr_data.value = req_reg.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // probe sequencer
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_fval_next   = res_fval_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_fval_next     = m_fval_reg;
        m_slot_next     = m_slot_reg;
        case (state_reg)
            B_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (q_valid) begin
                    req_next   = q_req;
                    pos_next   = q_home;
                    cnt_next   = '0;
                    state_next = B_READ;
                end
            end
            B_READ: begin
                state_next = B_CHECK;
            end
            B_CHECK: begin
                res_fval_next = '0;
                res_slot_next = '0;
                state_next    = B_FINISH;
                if (!rdata_reg.occ) begin
                    // empty slot ends both inserts and searches
                    if (is_insert) begin
                        res_status_next = lpht_pkg::ST_INSERTED;
                        res_slot_next   = pos_reg;
                    end else begin
                        res_status_next = lpht_pkg::ST_MISSING;
                    end
                end else if (!is_insert && key_match) begin
                    res_status_next = lpht_pkg::ST_FOUND;
                    res_fval_next   = rdata_reg.value;
                    res_slot_next   = pos_reg;
                end else if (cnt_reg == LAST_IDX) begin
                    // whole lap done
                    res_status_next = is_insert ? lpht_pkg::ST_FULL : lpht_pkg::ST_MISSING;
                end else begin
                    pos_next   = pos_inc;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = B_CHECK;
                end
            end
            B_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_fval_next   = res_fval_reg;
                    m_slot_next   = lpht_pkg::SLOT_W'(res_slot_reg);
                    state_next    = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg        <= req_next;
        pos_reg        <= pos_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_fval_reg   <= res_fval_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_fval_reg     <= m_fval_next;
        m_slot_reg     <= m_slot_next;
    end

endmodule

[src/linear_probe_hash_table.sv]
// Result path: the front registers the quotient, then the remainder, and pushes into the
// queue; the engine takes the request, reads its home slot, checks k probed slots
// (1 <= k <= TABLE_SLOTS) and registers the result. The single read port of the slot memory
// probes one slot per cycle; the front takes no new request until it has pushed the last one.
// Reset: synchronous, active low; afterwards a sweep clears the occupied marks of every slot,
// and no request is accepted until it completes.
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [lpht_pkg::KEY_W-1:0]    s_key,
    input  logic [lpht_pkg::VALUE_W-1:0]  s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [lpht_pkg::VALUE_W-1:0]  m_found_value,
    output logic [lpht_pkg::SLOT_W-1:0]   m_slot
);

    localparam int IDX_W  = $clog2(TABLE_SLOTS);
    localparam int Q_W    = $bits(lpht_pkg::lpht_req_t) + IDX_W;

    logic                 clearing;
    logic                 push_valid, push_ready;
    lpht_pkg::lpht_req_t  push_req;
    logic [IDX_W-1:0]     push_home;
    logic                 q_valid, q_ready;
    logic [Q_W-1:0]       q_data;
    lpht_pkg::lpht_req_t  q_req;
    logic [IDX_W-1:0]     q_home;

    // request intake and home slot
    lpht_front #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .hold       (clearing),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_key      (s_key),
        .s_value    (s_value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .push_home  (push_home)
    );

    // decoupling queue
    lpht_fifo #(
        .DATA_W (Q_W)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_req, push_home}),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    assign q_req  = q_data[Q_W-1:IDX_W];
    assign q_home = q_data[IDX_W-1:0];

    // probe engine and result register
    lpht_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clearing      (clearing),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_req         (q_req),
        .q_home        (q_home),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_value (m_found_value),
        .m_slot        (m_slot)
    );

endmodule

[verif/lpht_checker.sv]
// lpht_checker: watches both channels of the linear-probing hash table,
// predicts every result from its own copy of the table and compares them
// depends on lpht_pkg for request and status codes and field widths
module lpht_checker #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [lpht_pkg::KEY_W-1:0]    s_key,
    input  logic [lpht_pkg::VALUE_W-1:0]  s_value,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [1:0]                    m_status,
    input  logic [lpht_pkg::VALUE_W-1:0]  m_found_value,
    input  logic [lpht_pkg::SLOT_W-1:0]   m_slot,
    output int                            mismatch_count,
    output int                            pending_results
);

    typedef struct packed {
        lpht_pkg::lpht_status_t          status;
        logic [lpht_pkg::VALUE_W-1:0]    found_value;
        logic [lpht_pkg::SLOT_W-1:0]     slot;
    } lpht_result_t;

    // shadow copy of the table
    logic                          slot_used    [TABLE_SLOTS];
    logic [lpht_pkg::KEY_W-1:0]    table_keys   [TABLE_SLOTS];
    logic [lpht_pkg::VALUE_W-1:0]  table_values [TABLE_SLOTS];

    // results still owed by the block, oldest first
    lpht_result_t expected_results [$];

    // walk the probe sequence from the home slot, updating the shadow table
    function automatic lpht_result_t probe_table(lpht_pkg::lpht_op_t op,
                                                 logic [lpht_pkg::KEY_W-1:0] key,
                                                 logic [lpht_pkg::VALUE_W-1:0] value);
        lpht_result_t res;
        int           pos;
        res.status      = (op == lpht_pkg::OP_INSERT) ? lpht_pkg::ST_FULL
                                                      : lpht_pkg::ST_MISSING;
        res.found_value = '0;
        res.slot        = '0;
        pos = int'(key) % TABLE_SLOTS;
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            if (op == lpht_pkg::OP_INSERT) begin
                if (!slot_used[pos]) begin
                    slot_used[pos]    = 1'b1;
                    table_keys[pos]   = key;
                    table_values[pos] = value;
                    res.status        = lpht_pkg::ST_INSERTED;
                    res.slot          = lpht_pkg::SLOT_W'(pos);
                    return res;
                end
            end else begin
                // an empty slot ends the search
                if (!slot_used[pos]) begin
                    return res;
                end
                if (table_keys[pos] == key) begin
                    res.status      = lpht_pkg::ST_FOUND;
                    res.found_value = table_values[pos];
                    res.slot        = lpht_pkg::SLOT_W'(pos);
                    return res;
                end
            end
            pos = (pos + 1 == TABLE_SLOTS) ? 0 : pos + 1;
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d, at %0t", field, got, want, $time);
        mismatch_count++;
    endtask

    // compare result transfers first, then predict the accepted request
    always @(posedge aclk) begin
        lpht_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                slot_used[i] = 1'b0;
            end
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result transfer", int'(m_status), -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status) begin
                        report_mismatch("status", int'(m_status), int'(want.status));
                    end
                    if (m_found_value !== want.found_value) begin
                        report_mismatch("found_value", int'(m_found_value),
                                        int'(want.found_value));
                    end
                    if (m_slot !== want.slot) begin
                        report_mismatch("slot", int'(m_slot), int'(want.slot));
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(probe_table(lpht_pkg::lpht_op_t'(s_opcode),
                                                       s_key, s_value));
            end
        end
        pending_results = expected_results.size();
    end

endmodule

[verif/tb_linear_probe_hash_table.sv]
// tb_linear_probe_hash_table: drives insert and search requests with random
// gaps and result stalls, and gives the verdict from the checker's count
// depends on lpht_pkg, linear_probe_hash_table and lpht_checker
module tb_linear_probe_hash_table;

    localparam int TABLE_SLOTS = 16;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_opcode;
    logic [lpht_pkg::KEY_W-1:0]    s_key;
    logic [lpht_pkg::VALUE_W-1:0]  s_value;
    logic                          m_valid;
    logic                          m_ready;
    logic [1:0]                    m_status;
    logic [lpht_pkg::VALUE_W-1:0]  m_found_value;
    logic [lpht_pkg::SLOT_W-1:0]   m_slot;

    int mismatch_count;
    int pending_results;
    int src_burst;
    int snk_burst;

    // keys handed in by inserts, reused to make searches hit
    logic [lpht_pkg::KEY_W-1:0] stored_keys [$];

    linear_probe_hash_table #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_key         (s_key),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_value (m_found_value),
        .m_slot        (m_slot)
    );

    lpht_checker #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_key           (s_key),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found_value   (m_found_value),
        .m_slot          (m_slot),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // clock, period 8
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // wait before the next transfer; now and then a run with no waiting
    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(4, 24);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // one request transfer; returns at the falling edge after acceptance
    task automatic send_item(lpht_pkg::lpht_op_t op, logic [lpht_pkg::KEY_W-1:0] key,
                             logic [lpht_pkg::VALUE_W-1:0] value);
        int gap;
        gap = draw_wait(src_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_opcode <= op;
        s_key    <= key;
        s_value  <= value;
        s_valid  <= 1'b1;
        if (op == lpht_pkg::OP_INSERT) begin
            stored_keys.push_back(key);
        end
        do @(posedge aclk); while (!(s_valid && s_ready === 1'b1));
        @(negedge aclk);
    endtask

    // hold the sender off until every owed result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results != 0);
    endtask

    // result side: random stall before each transfer
    initial begin
        int stall;
        m_ready   = 1'b0;
        snk_burst = 0;
        @(negedge aclk);
        forever begin
            stall = draw_wait(snk_burst);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready));
            @(negedge aclk);
        end
    end

    // stimulus and verdict
    initial begin
        int pick;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_opcode  = 1'b0;
        s_key     = '0;
        s_value   = '0;
        src_burst = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // search in an empty table stops at the empty home slot
        send_item(lpht_pkg::OP_SEARCH, 16'h0000, 16'hFFFF);
        send_item(lpht_pkg::OP_INSERT, 16'h0000, 16'hFFFF);
        send_item(lpht_pkg::OP_INSERT, 16'hFFFF, 16'h0000);
        // collision on home slot 0, then a duplicate key
        send_item(lpht_pkg::OP_INSERT, 16'h0010, 16'h1234);
        send_item(lpht_pkg::OP_INSERT, 16'h0000, 16'hA5A5);
        // duplicate key: the earlier entry is found
        send_item(lpht_pkg::OP_SEARCH, 16'h0000, 16'h0000);
        send_item(lpht_pkg::OP_SEARCH, 16'h0010, 16'h0000);
        // probes past the cluster to an empty slot
        send_item(lpht_pkg::OP_SEARCH, 16'h0020, 16'h0000);
        // home slot 15 taken, probing wraps to slot 0 and on
        send_item(lpht_pkg::OP_INSERT, 16'h000F, 16'h5A5A);
        send_item(lpht_pkg::OP_SEARCH, 16'h000F, 16'hFFFF);
        send_item(lpht_pkg::OP_SEARCH, 16'hFFFF, 16'h0000);
        // fill the remaining slots
        for (int i = 0; i < 11; i++) begin
            send_item(lpht_pkg::OP_INSERT,
                      lpht_pkg::KEY_W'((($urandom_range(0, 4095)) << 4) | (i + 4)),
                      lpht_pkg::VALUE_W'($urandom));
        end
        // full table on insert, then a miss after a whole lap
        send_item(lpht_pkg::OP_INSERT, 16'h8000, 16'hFFFF);
        send_item(lpht_pkg::OP_SEARCH, 16'h7FFF, 16'hFFFF);
        drain_results();

        // random mix of hits, misses and inserts into the full table
        for (int i = 0; i < 800; i++) begin
            if (i == 400) begin
                drain_results();
            end
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                send_item(lpht_pkg::OP_INSERT, lpht_pkg::KEY_W'($urandom),
                          lpht_pkg::VALUE_W'($urandom));
            end else if (pick < 7) begin
                send_item(lpht_pkg::OP_SEARCH,
                          stored_keys[$urandom_range(0, stored_keys.size() - 1)],
                          lpht_pkg::VALUE_W'($urandom));
            end else begin
                send_item(lpht_pkg::OP_SEARCH, lpht_pkg::KEY_W'($urandom),
                          lpht_pkg::VALUE_W'($urandom));
            end
        end

        drain_results();
        repeat (48) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
